FILE: hdl/kfli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfli_pkg
// Types and constants shared by the keyframe interpolator modules.
// ----------------------------------------------------------------------------
package kfli_pkg;

  localparam int unsigned MaxFrames = 16;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned ValW      = 32;
  localparam int unsigned NumComp   = 7;
  localparam int unsigned PoseW     = NumComp * ValW;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_EVAL   = 2'd1;
  localparam logic [1:0] CMD_REACT  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [16:0] WeightOne = 17'd65536;

  typedef struct packed {
    logic [1:0]         command;
    logic [IdxW-1:0]    frame_index;
    logic signed [31:0] frame_key;
    logic signed [31:0] query_value;
    logic signed [31:0] load_offset_x;
    logic signed [31:0] load_offset_y;
    logic signed [31:0] load_align_x;
    logic signed [31:0] load_align_y;
    logic signed [31:0] load_size_x;
    logic signed [31:0] load_size_y;
    logic signed [31:0] load_angle;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] align_x;
    logic signed [31:0] align_y;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic signed [31:0] angle;
    logic [16:0]        low_weight;
  } out_word_t;

  // divider control
  typedef struct packed {
    logic        start;
    logic [32:0] numer;
    logic [32:0] span;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: hdl/kfli_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfli_div
// Restoring divider: floor(numer * 65536 / span), one quotient bit per cycle,
// valid for numer < 2*span, with no clamp to 65536. Operands positive.
// ----------------------------------------------------------------------------
module kfli_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire kfli_pkg::div_req_t req_i,
  output kfli_pkg::div_rsp_t     rsp_o
);

  logic [33:0] rem_q, rem_d;
  logic [32:0] span_q, span_d;
  logic [16:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [33:0] trial;
  logic [33:0] shifted;

  always_comb begin
    shifted = {rem_q[32:0], 1'b0};
    trial   = shifted - {1'b0, span_q};
    rem_d   = rem_q;
    span_d  = span_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      // first step: integer part of numer/span by one compare, so at most 1
      busy_d = 1'b1;
      span_d = req_i.span;
      cnt_d  = 5'd16;
      if ({1'b0, req_i.numer} >= {1'b0, req_i.span}) begin
        rem_d = {1'b0, req_i.numer} - {1'b0, req_i.span};
        quo_d = 17'd1;
      end else begin
        rem_d = {1'b0, req_i.numer};
        quo_d = 17'd0;
      end
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_d = trial;
        quo_d = {quo_q[15:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[15:0], 1'b0};
      end
      // saturation test on bit 16; the integer bit never reaches it here
      if (quo_q[16]) quo_d = kfli_pkg::WeightOne;
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    span_q <= span_d;
    quo_q  <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule
`default_nettype wire

FILE: hdl/kfli_blend.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfli_blend
// Shared blend unit: (lo*w + hi*(1-w) + half) >> 16, written as
// hi + ((lo-hi)*w + half) >> 16. Two register stages.
// ----------------------------------------------------------------------------
module kfli_blend (
  input  wire logic               clk_i,
  input  wire logic signed [31:0] lo_i,
  input  wire logic signed [31:0] hi_i,
  input  wire logic [16:0]        w_i,
  output logic signed [31:0]      res_o
);

  logic signed [32:0] diff_q;
  logic signed [31:0] hi_q, hi2_q;
  logic [16:0]        w_q;
  logic signed [50:0] prod_q;
  logic signed [50:0] sum;

  always_ff @(posedge clk_i) begin
    diff_q <= 33'(lo_i) - 33'(hi_i);
    hi_q   <= hi_i;
    w_q    <= w_i;
    prod_q <= 51'(diff_q) * 51'($signed({1'b0, w_q}));
    hi2_q  <= hi_q;
  end

  always_comb begin
    sum   = (prod_q + 51'sd32768) >>> 16;
    res_o = 32'(sum) + hi2_q;
  end

endmodule
`default_nettype wire

FILE: hdl/keyframe_linear_interpolator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_top
// Keyframe table with serial key scan, iterative divider and a shared blend
// unit that is reused for the seven pose components.
// ----------------------------------------------------------------------------
//  channel  | signals                         | dir
//  in       | in_valid_i in_stall_o in_word_i | in
//  out      | out_valid_o out_stall_i out_word_o | out
//  cfg      | cfg_we_i cfg_wdata_i            | in
//
// Load writes the frame in its accept cycle. Evaluate: the accept cycle,
// one cycle per key scanned, a divide when the query lies above one key
// and at or below the next, blending through the two-stage blend multiplier
// and a fill of the output register. An EVAL of the last query is dropped.
// Reset clears control, the filter and frames_in_use (to 1); the tables are
// not cleared. The result waits in the output register while out is stalled;
// a new word is taken only after it leaves.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator_top (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire kfli_pkg::in_word_t   in_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output kfli_pkg::out_word_t       out_word_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [4:0]           cfg_wdata_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_BLEND = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] st_q, st_d;
  logic [4:0] frames_q;
  logic [31:0] lastq_q;
  logic        lastv_q;

  logic signed [31:0] key_mem [kfli_pkg::MaxFrames];
  logic [kfli_pkg::PoseW-1:0] pose_mem [kfli_pkg::MaxFrames];

  logic signed [31:0] q_q;
  logic [4:0]  n_q;
  logic [4:0]  i_q;
  logic [3:0]  lo_q;
  logic signed [31:0] klo_q;
  logic [16:0] w_q;
  logic [3:0]  bc_q;
  logic [kfli_pkg::PoseW-1:0] plo_q, phi_q;
  logic [kfli_pkg::PoseW-1:0] acc_q;
  logic        out_v_q;
  kfli_pkg::out_word_t out_q;

  kfli_pkg::div_req_t dreq;
  kfli_pkg::div_rsp_t drsp;
  logic signed [31:0] b_lo, b_hi, b_res;

  logic accept;
  logic signed [31:0] kcur;
  logic signed [32:0] qdiff, span;
  logic [4:0] nsat;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != ST_IDLE) || out_v_q;
  assign kcur       = key_mem[i_q[3:0]];
  assign qdiff      = 33'(q_q) - 33'(klo_q);
  assign span       = 33'(kcur) - 33'(klo_q);
  assign nsat       = (cfg_wdata_i == 5'd0) ? 5'd1 : cfg_wdata_i;

  kfli_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (dreq),
    .rsp_o (drsp)
  );

  kfli_blend u_blend (
    .clk_i(clk_i),
    .lo_i (b_lo),
    .hi_i (b_hi),
    .w_i  (w_q),
    .res_o(b_res)
  );

  // component select: top component first
  assign b_lo = plo_q[kfli_pkg::PoseW-1 -: 32];
  assign b_hi = phi_q[kfli_pkg::PoseW-1 -: 32];

  always_ff @(posedge clk_i) begin
    if (accept && in_word_i.command == kfli_pkg::CMD_LOAD) begin
      key_mem[in_word_i.frame_index]  <= in_word_i.frame_key;
      pose_mem[in_word_i.frame_index] <= {in_word_i.load_offset_x,
        in_word_i.load_offset_y, in_word_i.load_align_x, in_word_i.load_align_y,
        in_word_i.load_size_x, in_word_i.load_size_y, in_word_i.load_angle};
    end
  end

  always_comb begin
    dreq.start = 1'b0;
    dreq.numer = qdiff;
    dreq.span  = span;
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (accept && (in_word_i.command == kfli_pkg::CMD_EVAL ||
                       in_word_i.command == kfli_pkg::CMD_REACT)) begin
          if (in_word_i.command == kfli_pkg::CMD_REACT || !lastv_q ||
              in_word_i.query_value != lastq_q) st_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (kcur >= q_q) begin
          if (i_q == 5'd0 || qdiff <= 0 || span <= 0) st_d = ST_BLEND;
          else begin
            st_d = ST_DIV;
            dreq.start = 1'b1;
          end
        end else if (i_q == n_q - 5'd1) st_d = ST_BLEND;
      end
      ST_DIV:   if (drsp.done) st_d = ST_BLEND;
      ST_BLEND: if (bc_q == 4'd8) st_d = ST_OUT;
      ST_OUT:   st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      frames_q <= 5'd1;
      lastq_q  <= '0;
      lastv_q  <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) frames_q <= (nsat > 5'd16) ? 5'd16 : nsat;
      if (accept && (in_word_i.command == kfli_pkg::CMD_EVAL ||
                     in_word_i.command == kfli_pkg::CMD_REACT)) begin
        lastq_q <= in_word_i.query_value;
        lastv_q <= 1'b1;
      end
      if (st_q == ST_OUT) out_v_q <= 1'b1;
      else if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        q_q  <= in_word_i.query_value;
        n_q  <= frames_q;
        i_q  <= '0;
        lo_q <= '0;
        bc_q <= '0;
      end
      ST_SCAN: begin
        if (kcur >= q_q) begin
          if (i_q == 5'd0 || qdiff <= 0) w_q <= kfli_pkg::WeightOne;
          else if (span <= 0) w_q <= '0;
          plo_q <= pose_mem[lo_q];
          phi_q <= pose_mem[i_q[3:0]];
        end else begin
          lo_q  <= i_q[3:0];
          klo_q <= kcur;
          if (i_q == n_q - 5'd1) begin
            w_q   <= '0;
            plo_q <= pose_mem[i_q[3:0]];
            phi_q <= pose_mem[i_q[3:0]];
          end
        end
        i_q <= i_q + 5'd1;
      end
      ST_DIV: if (drsp.done) w_q <= kfli_pkg::WeightOne - drsp.quo;
      ST_BLEND: begin
        bc_q  <= bc_q + 4'd1;
        plo_q <= {plo_q[kfli_pkg::PoseW-33:0], 32'd0};
        phi_q <= {phi_q[kfli_pkg::PoseW-33:0], 32'd0};
        if (bc_q >= 4'd2)
          acc_q <= {acc_q[kfli_pkg::PoseW-33:0], b_res};
      end
      ST_OUT: begin
        out_q <= {acc_q, w_q};
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

  property p_no_take_busy;
    @(posedge clk_i) disable iff (!rst_ni) (st_q != ST_IDLE) |-> in_stall_o;
  endproperty
  a_no_take_busy: assert property (p_no_take_busy) else $error("accept while busy");

  property p_out_from_out;
    @(posedge clk_i) disable iff (!rst_ni) $rose(out_valid_o) |-> $past(st_q) == ST_OUT;
  endproperty
  a_out_from_out: assert property (p_out_from_out) else $error("stray result");

  property p_weight_range;
    @(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> out_word_o.low_weight <= 17'd65536;
  endproperty
  a_weight_range: assert property (p_weight_range) else $error("weight range");

endmodule
`default_nettype wire
